[sv/adu_pkg.sv]
// Shared types, constants and helper functions of the ASCII distance unit converter.
package adu_pkg;

	// Number width and magnitude limit
	localparam int VALUE_W = 32;
	localparam int MAG_W = VALUE_W;
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

	// Configuration register widths and reset values
	localparam int DPI_W = 17;
	localparam int SCRW_W = 16;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam logic [DPI_W-1:0] DPI_RESET = DPI_W'(96);
	localparam logic [SCRW_W-1:0] SCRW_RESET = SCRW_W'(1024);

	// Scale factor and divider widths
	localparam int K_W = 23;
	localparam int REM_W = 14;
	localparam int HIK_W = 48;
	localparam int SUM_W = HIK_W + 1;

	// Stream payload widths
	localparam int CHAR_W = 8;
	localparam int OUT_TDATA_W = 40;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DPI   = 1'b0,
		REG_WIDTH = 1'b1
	} cfg_reg_t;

	// Constant divisors (fractions reduced: 100/254 = 50/127, 10/254 = 5/127)
	typedef enum logic [1:0] {
		DIV_72,
		DIV_127,
		DIV_10000
	} div_sel_t;

	localparam logic [REM_W-1:0] DIVISOR_72 = REM_W'(72);
	localparam logic [REM_W-1:0] DIVISOR_127 = REM_W'(127);
	localparam logic [REM_W-1:0] DIVISOR_10000 = REM_W'(10000);
	localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);
	localparam logic [31:0] RECIP_127 = 32'((64'd1 << 32) / 127);
	localparam logic [31:0] RECIP_10000 = 32'((64'd1 << 32) / 10000);

	// Parse phases
	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_ZERO,
		PH_XPEND,
		PH_DIGITS,
		PH_AFTER,
		PH_NONUM
	} phase_t;

	typedef enum logic [1:0] {
		RX_DEC,
		RX_OCT,
		RX_HEX
	} radix_t;

	typedef enum logic [2:0] {
		UNIT_NONE,
		UNIT_PT,
		UNIT_CM,
		UNIT_MM,
		UNIT_PX
	} unit_t;

	// Finished string handed from the parser to the scaler
	typedef struct packed {
		logic              ok;
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic [K_W-1:0]    k;
		div_sel_t          dsel;
	} fin_t;

	// Sideband through the first divider
	typedef struct packed {
		logic           ok;
		logic           neg;
		logic [K_W-1:0] k;
		div_sel_t       dsel;
	} side_a_t;

	// Sideband through the second divider
	typedef struct packed {
		logic             ok;
		logic             neg;
		logic [HIK_W-1:0] hik;
	} side_b_t;

	function automatic logic [REM_W-1:0] div_const(div_sel_t sel);
		logic [REM_W-1:0] d;
		case (sel)
			DIV_72:    d = DIVISOR_72;
			DIV_127:   d = DIVISOR_127;
			DIV_10000: d = DIVISOR_10000;
			default:   d = DIVISOR_72;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] div_recip(div_sel_t sel);
		logic [31:0] r;
		case (sel)
			DIV_72:    r = RECIP_72;
			DIV_127:   r = RECIP_127;
			DIV_10000: r = RECIP_10000;
			default:   r = RECIP_72;
		endcase
		return r;
	endfunction

endpackage

[sv/adu_parser.sv]
// Character parser: number, sign, radix and unit suffix tracking, finish record register.
module adu_parser import adu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  logic [CHAR_W-1:0]    char_data,
	input  logic [DPI_W-1:0]     dpi,
	input  logic [SCRW_W-1:0]    scr_width,
	output logic                 fin_valid,
	input  logic                 fin_ready,
	output fin_t                 fin
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UC    = 8'h43;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UM    = 8'h4D;
	localparam logic [7:0] CH_UP    = 8'h50;
	localparam logic [7:0] CH_UT    = 8'h54;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	localparam int ACC_W = MAG_W + 5;

	function automatic logic [7:0] to_upper(logic [7:0] c);
		logic [7:0] u;
		u = (c inside {[CH_LA:CH_LZ]}) ? c - CASE_GAP : c;
		return u;
	endfunction

	// Digit value in the low four bits, bit 4 set when c is a digit of radix rx
	function automatic logic [4:0] digit_of(logic [7:0] c, radix_t rx);
		logic [7:0] u;
		logic [7:0] v;
		logic       ok;
		u = to_upper(c);
		ok = 1'b1;
		v = 8'd0;
		if (c inside {[CH_0:CH_9]}) begin
			v = c - CH_0;
		end else if (u inside {[CH_UA:CH_UF]}) begin
			v = u - CH_UA + 8'd10;
		end else begin
			ok = 1'b0;
		end
		if (rx == RX_DEC && v > 8'd9) ok = 1'b0;
		if (rx == RX_OCT && v > 8'd7) ok = 1'b0;
		return {ok, v[3:0]};
	endfunction

	// Parse state
	phase_t            phase_q, phase_d;
	logic [MAG_W-1:0]  mag_q, mag_d;
	logic              neg_q, neg_d;
	radix_t            radix_q, radix_d;
	logic [1:0]        tlen_q, tlen_d;
	logic [1:0]        after_q, after_d;
	logic              fol_q, fol_d;
	logic [7:0]        prev_q, prev_d;
	logic [7:0]        last_q, last_d;

	logic              fin_valid_q;
	fin_t              fin_q;
	fin_t              fin_d;

	logic              take;
	logic [7:0]        c;
	logic [4:0]        dig_cur;
	logic [4:0]        dig_oct;
	logic [4:0]        dig_hex;
	logic [ACC_W-1:0]  acc;
	phase_t            st_phase;
	logic [MAG_W-1:0]  st_mag;

	assign c = char_data;
	assign char_ready = !fin_valid_q || fin_ready;
	assign take = char_valid && char_ready;

	assign dig_cur = digit_of(c, radix_q);
	assign dig_oct = digit_of(c, RX_OCT);
	assign dig_hex = digit_of(c, RX_HEX);

	// Shift-add accumulate of one digit
	always_comb begin
		case (radix_q)
			RX_HEX:  acc = {mag_q, 4'b0000} + ACC_W'(dig_cur[3:0]);
			RX_OCT:  acc = ACC_W'({mag_q, 3'b000}) + ACC_W'(dig_cur[3:0]);
			default: acc = ACC_W'({mag_q, 3'b000}) + ACC_W'({mag_q, 1'b0})
				+ ACC_W'(dig_cur[3:0]);
		endcase
	end

	// First character of a number
	always_comb begin
		st_mag = mag_q;
		if (c == CH_0) begin
			st_phase = PH_ZERO;
		end else if (c inside {[CH_1:CH_9]}) begin
			st_phase = PH_DIGITS;
			st_mag = MAG_W'(c - CH_0);
		end else begin
			st_phase = PH_NONUM;
		end
	end

	// Next parse state for one non-NUL character
	always_comb begin
		phase_d = phase_q;
		mag_d = mag_q;
		neg_d = neg_q;
		radix_d = radix_q;
		after_d = after_q;
		fol_d = fol_q;
		if (tlen_q == 2'd0) fol_d = (c == CH_SP);
		case (phase_q)
			PH_WS: begin
				if (!(c inside {CH_SP, [CH_TAB:CH_CR]})) begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg_d = (c == CH_MINUS);
						phase_d = PH_SIGN;
					end else begin
						phase_d = st_phase;
						mag_d = st_mag;
						if (st_phase == PH_DIGITS) radix_d = RX_DEC;
					end
				end
			end
			PH_SIGN: begin
				phase_d = st_phase;
				mag_d = st_mag;
				if (st_phase == PH_DIGITS) radix_d = RX_DEC;
			end
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					phase_d = PH_XPEND;
				end else if (dig_oct[4]) begin
					phase_d = PH_DIGITS;
					radix_d = RX_OCT;
					mag_d = MAG_W'(dig_oct[3:0]);
				end else begin
					phase_d = PH_AFTER;
					fol_d = (c == CH_SP);
					after_d = 2'd1;
				end
			end
			PH_XPEND: begin
				if (dig_hex[4]) begin
					phase_d = PH_DIGITS;
					radix_d = RX_HEX;
					mag_d = MAG_W'(dig_hex[3:0]);
				end else begin
					phase_d = PH_AFTER;
					fol_d = 1'b0;
					after_d = 2'd2;
				end
			end
			PH_DIGITS: begin
				if (dig_cur[4]) begin
					mag_d = (acc > ACC_W'(MAG_CAP)) ? MAG_CAP : acc[MAG_W-1:0];
				end else begin
					phase_d = PH_AFTER;
					fol_d = (c == CH_SP);
					after_d = 2'd1;
				end
			end
			PH_AFTER: begin
				if (after_q != 2'd3) after_d = after_q + 2'd1;
			end
			default: begin
			end
		endcase
		tlen_d = (tlen_q == 2'd3) ? tlen_q : tlen_q + 2'd1;
		prev_d = last_q;
		last_d = c;
	end

	// Finish record from the state before the NUL
	always_comb begin
		logic             num_end;
		logic             fol_f;
		logic [1:0]       after_f;
		logic             has_dig;
		logic [7:0]       ua;
		logic [7:0]       ub;
		unit_t            unit;
		logic [MAG_W-1:0] lim;
		logic [MAG_W-1:0] m0;
		num_end = (phase_q == PH_ZERO) || (phase_q == PH_DIGITS);
		if (num_end) begin
			fol_f = 1'b1;
			after_f = 2'd0;
		end else if (phase_q == PH_XPEND) begin
			fol_f = 1'b0;
			after_f = 2'd1;
		end else begin
			fol_f = fol_q;
			after_f = after_q;
		end
		has_dig = phase_q inside {PH_ZERO, PH_XPEND, PH_DIGITS, PH_AFTER};
		ua = to_upper(prev_q);
		ub = to_upper(last_q);
		unit = UNIT_NONE;
		if (tlen_q == 2'd3) begin
			if (ua == CH_UP && ub == CH_UT) unit = UNIT_PT;
			else if (ua == CH_UC && ub == CH_UM) unit = UNIT_CM;
			else if (ua == CH_UM && ub == CH_UM) unit = UNIT_MM;
			else if (ua == CH_UP && ub == CH_UX) unit = UNIT_PX;
		end
		lim = neg_q ? MAG_CAP : MAG_CAP - MAG_W'(1);
		m0 = has_dig ? mag_q : '0;
		fin_d.neg = neg_q;
		fin_d.mag = (m0 > lim) ? lim : m0;
		if (tlen_q == 2'd0) fin_d.ok = 1'b0;
		else if (unit == UNIT_NONE) fin_d.ok = fol_f;
		else fin_d.ok = has_dig && (after_f == 2'd2);
		// Plain numbers pass through as m * 72 / 72
		case (unit)
			UNIT_PT: begin
				fin_d.k = K_W'(dpi);
				fin_d.dsel = DIV_72;
			end
			UNIT_CM: begin
				fin_d.k = K_W'(dpi) * K_W'(50);
				fin_d.dsel = DIV_127;
			end
			UNIT_MM: begin
				fin_d.k = K_W'(dpi) * K_W'(5);
				fin_d.dsel = DIV_127;
			end
			UNIT_PX: begin
				fin_d.k = K_W'(scr_width);
				fin_d.dsel = DIV_10000;
			end
			default: begin
				fin_d.k = K_W'(72);
				fin_d.dsel = DIV_72;
			end
		endcase
	end

	// Advance parse state; NUL clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			mag_q <= '0;
			neg_q <= 1'b0;
			radix_q <= RX_DEC;
			tlen_q <= 2'd0;
			after_q <= 2'd0;
			fol_q <= 1'b1;
			prev_q <= '0;
			last_q <= '0;
		end else if (take) begin
			if (c == CH_NUL) begin
				phase_q <= PH_WS;
				mag_q <= '0;
				neg_q <= 1'b0;
				radix_q <= RX_DEC;
				tlen_q <= 2'd0;
				after_q <= 2'd0;
				fol_q <= 1'b1;
				prev_q <= '0;
				last_q <= '0;
			end else begin
				phase_q <= phase_d;
				mag_q <= mag_d;
				neg_q <= neg_d;
				radix_q <= radix_d;
				tlen_q <= tlen_d;
				after_q <= after_d;
				fol_q <= fol_d;
				prev_q <= prev_d;
				last_q <= last_d;
			end
		end
	end

	// Hold the finish record until the scaler takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
		end else if (char_ready) begin
			fin_valid_q <= take && (c == CH_NUL);
		end
	end

	always_ff @(posedge clk) begin
		if (take && c == CH_NUL) begin
			fin_q <= fin_d;
		end
	end

	assign fin_valid = fin_valid_q;
	assign fin = fin_q;

endmodule

[sv/adu_cdiv.sv]
// Three-stage divider of a 32-bit value by a selected constant (reciprocal plus correction).
module adu_cdiv import adu_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       in_num,
	input  div_sel_t          in_dsel,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       out_quo,
	output logic [REM_W-1:0]  out_rem,
	output logic [SIDE_W-1:0] out_side
);

	logic              v_s1, v_s2, v_s3;
	logic              en_s1, en_s2, en_s3;
	logic [31:0]       num_s1;
	logic [31:0]       q0_s1, q0_s2;
	div_sel_t          dsel_s1, dsel_s2;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [REM_W:0]    rem_s2;
	logic [31:0]       quo_s3;
	logic [REM_W-1:0]  rem_s3;

	logic [63:0]       prod;
	logic [45:0]       q0d;
	logic [REM_W-1:0]  d_s2;

	// Each stage moves when it is empty or its successor moves
	assign en_s3 = !v_s3 || out_ready;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign prod = 64'(in_num) * 64'(div_recip(in_dsel));
	assign q0d = 46'(q0_s1) * 46'(div_const(dsel_s1));
	assign d_s2 = div_const(dsel_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Estimate quotient, then remainder, then fix an estimate one too low
	always_ff @(posedge clk) begin
		if (en_s1) begin
			num_s1 <= in_num;
			q0_s1 <= prod[63:32];
			dsel_s1 <= in_dsel;
			side_s1 <= in_side;
		end
		if (en_s2) begin
			q0_s2 <= q0_s1;
			rem_s2 <= (REM_W+1)'(num_s1 - q0d[31:0]);
			dsel_s2 <= dsel_s1;
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			if (rem_s2 >= {1'b0, d_s2}) begin
				quo_s3 <= q0_s2 + 32'd1;
				rem_s3 <= REM_W'(rem_s2 - {1'b0, d_s2});
			end else begin
				quo_s3 <= q0_s2;
				rem_s3 <= rem_s2[REM_W-1:0];
			end
			side_s3 <= side_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_quo = quo_s3;
	assign out_rem = rem_s3;
	assign out_side = side_s3;

endmodule

[sv/adu_scaler.sv]
// Scaling pipeline: m*k/d by split division, clamp, sign and result register.
module adu_scaler import adu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fin_valid,
	output logic               fin_ready,
	input  fin_t               fin,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               res_ok,
	output logic [VALUE_W-1:0] res_value
);

	side_a_t           side_a_in, side_a_out;
	side_b_t           side_b_in, side_b_out;
	logic [31:0]       quo_a, quo_b;
	logic [REM_W-1:0]  rem_a;
	logic              div_a_valid, div_a_ready;
	logic              div_b_valid, div_b_ready;

	logic              v_s4, v_s8, v_s9;
	logic              en_s4, en_s8, en_s9;
	side_b_t           side_s4;
	logic [31:0]       rk_s4;
	div_sel_t          dsel_s4;
	logic              ok_s8, neg_s8;
	logic [MAG_W-1:0]  q_s8;
	logic              ok_s9;
	logic [VALUE_W-1:0] val_s9;

	logic [54:0]       hik_full;
	logic [36:0]       rk_full;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  lim;

	assign side_a_in.ok = fin.ok;
	assign side_a_in.neg = fin.neg;
	assign side_a_in.k = fin.k;
	assign side_a_in.dsel = fin.dsel;

	// Whole quotient and remainder of m / d
	adu_cdiv #(
		.SIDE_W($bits(side_a_t))
	) u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fin_valid),
		.in_ready (fin_ready),
		.in_num   (fin.mag),
		.in_dsel  (fin.dsel),
		.in_side  (side_a_in),
		.out_valid(div_a_valid),
		.out_ready(en_s4),
		.out_quo  (quo_a),
		.out_rem  (rem_a),
		.out_side (side_a_out)
	);

	// Scale both parts by k
	assign hik_full = 55'(quo_a) * 55'(side_a_out.k);
	assign rk_full = 37'(rem_a) * 37'(side_a_out.k);
	assign en_s4 = !v_s4 || div_b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= div_a_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			side_s4.ok <= side_a_out.ok;
			side_s4.neg <= side_a_out.neg;
			side_s4.hik <= hik_full[HIK_W-1:0];
			rk_s4 <= rk_full[31:0];
			dsel_s4 <= side_a_out.dsel;
		end
	end

	assign side_b_in = side_s4;

	// Fractional part (r * k) / d
	adu_cdiv #(
		.SIDE_W($bits(side_b_t))
	) u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.in_ready (div_b_ready),
		.in_num   (rk_s4),
		.in_dsel  (dsel_s4),
		.in_side  (side_b_in),
		.out_valid(div_b_valid),
		.out_ready(en_s8),
		.out_quo  (quo_b),
		.out_rem  (),
		.out_side (side_b_out)
	);

	// Sum and clamp to the signed range
	assign sum = {1'b0, side_b_out.hik} + SUM_W'(quo_b);
	assign lim = side_b_out.neg ? SUM_W'(MAG_CAP) : SUM_W'(MAG_CAP) - SUM_W'(1);
	assign en_s9 = !v_s9 || res_ready;
	assign en_s8 = !v_s8 || en_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s8) v_s8 <= div_b_valid;
			if (en_s9) v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			ok_s8 <= side_b_out.ok;
			neg_s8 <= side_b_out.neg;
			q_s8 <= (sum > lim) ? lim[MAG_W-1:0] : sum[MAG_W-1:0];
		end
		// Apply sign; drop the value of a rejected string
		if (en_s9) begin
			ok_s9 <= ok_s8;
			if (!ok_s8) val_s9 <= '0;
			else if (neg_s8) val_s9 <= VALUE_W'(-q_s8);
			else val_s9 <= VALUE_W'(q_s8);
		end
	end

	assign res_valid = v_s9;
	assign res_ok = ok_s9;
	assign res_value = val_s9;

endmodule

[sv/ascii_distance_unit_converter_unit.sv]
// Top level of the ASCII distance unit converter: stream ports and configuration registers.
//
// Usage: feed a string one byte per transaction on the s_axis channel; a NUL byte ends
// it and produces exactly one result transaction on m_axis. Other bytes produce none.
// The number is read like strtol with base 0 and may end in pt, cm, mm or px, which
// scale it by dots_per_inch/72, dots_per_inch*100/254, dots_per_inch*10/254 or
// screen_width_px/10000, truncating and saturating to signed 32 bits.
// Result: valid_res is 0 on a syntax error, and scaled_value is then 0.
// Configuration: write register 0 (dots_per_inch) or 1 (screen_width_px) over the cfg
// channel while no string is in flight; cfg_ready is always high.
// Throughput: one byte per cycle while s_axis_tready is high. Result path: the finish
// register loads on the NUL transaction, then come two 3-stage constant dividers,
// multiply, clamp and output registers.
// Receiver stall: m_axis holds its transaction; the pipeline keeps filling its empty
// stages and s_axis_tready falls only once the finish register is blocked.
// Reset: clears the parse state and all pipeline valids; registers return to
// dots_per_inch 96 and screen_width_px 1024.
module ascii_distance_unit_converter_unit import adu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CHAR_W-1:0]      s_axis_tdata,   // [7:0] character
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] valid_res, [32:1] scaled_value
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [DPI_W-1:0]   dpi_q;
	logic [SCRW_W-1:0]  scrw_q;
	logic               fin_valid, fin_ready;
	fin_t               fin;
	logic               res_ok;
	logic [VALUE_W-1:0] res_value;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpi_q <= DPI_RESET;
			scrw_q <= SCRW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DPI:   dpi_q <= cfg_data[DPI_W-1:0];
				REG_WIDTH: scrw_q <= cfg_data[SCRW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	adu_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(s_axis_tvalid),
		.char_ready(s_axis_tready),
		.char_data (s_axis_tdata),
		.dpi       (dpi_q),
		.scr_width (scrw_q),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin       (fin)
	);

	adu_scaler u_scaler (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin_valid(fin_valid),
		.fin_ready(fin_ready),
		.fin      (fin),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res_ok   (res_ok),
		.res_value(res_value)
	);

	// Pack result fields from the lowest bit up
	assign m_axis_tdata = {(OUT_TDATA_W - VALUE_W - 1)'(0), res_value, res_ok};

endmodule
